@@ design/rftq_pkg.sv @@
// shared types and constants of the repeat frame transmit queue
package rftq_pkg;

   localparam int QUEUE_DEPTH_DEF   = 8;
   localparam int MAX_FRAME_LEN_DEF = 32;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 4;
   localparam int BYTE_W   = 8;
   localparam int REPEAT_W = 8;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_SEND  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_BYTE   = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_META,
      S_BYTES
   } state_type;

endpackage

@@ design/repeat_frame_tx_queue_top.sv @@
// top level of the repeat frame transmit queue
// push: one byte word per cycle unless rsp stalls; status valid the cycle after the last byte
// send: the head entry is read from the entry memory, then frame bytes stream
//   out one per cycle unless rsp stalls; no request word is taken until the send ends
// a send with nothing to transmit, a clear and any other word give no result word
// reset clears pointers, counters and the output valid flag; memories keep their contents
module repeat_frame_tx_queue_top #(
   parameter int QUEUE_DEPTH   = rftq_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_FRAME_LEN = rftq_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rftq_pkg::REQ_TDATA_W-1:0] req_tdata,  // data_byte, repeat_count
   input  logic                             req_tlast,  // last_byte
   input  logic [rftq_pkg::CMD_W-1:0]       req_tuser,  // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rftq_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // push_status, frame_byte,
                                                        // queue_empty, queue_fill, pad
   output logic                             rsp_tlast,  // frame_last
   output logic                             rsp_tuser   // result_kind
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W  = $clog2(MAX_FRAME_LEN + 1);
   localparam int FRAME_WORDS = QUEUE_DEPTH * MAX_FRAME_LEN;
   localparam int ADDR_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
   localparam int META_W = IDX_W + rftq_pkg::REPEAT_W;

   rftq_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] bidx_ff, bidx_in;
   logic             too_long_ff, too_long_in;
   logic [PTR_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] send_idx_ff, send_idx_in;
   logic [IDX_W-1:0] send_len_ff, send_len_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_kind_ff, rsp_kind_in;
   logic [rftq_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [rftq_pkg::BYTE_W-1:0]       rsp_byte_ff, rsp_byte_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_empty_ff, rsp_empty_in;
   logic [rftq_pkg::FILL_W-1:0]       rsp_fill_ff, rsp_fill_in;

   logic [rftq_pkg::BYTE_W-1:0] frame_mem [FRAME_WORDS];
   logic                        frame_we, frame_re;
   logic [ADDR_W-1:0]           frame_waddr, frame_raddr;
   logic [rftq_pkg::BYTE_W-1:0] frame_q;

   logic [META_W-1:0] meta_mem [QUEUE_DEPTH];
   logic              meta_we, meta_re;
   logic [PTR_W-1:0]  meta_waddr;
   logic [META_W-1:0] meta_wdata;
   logic [META_W-1:0] meta_q;

   logic                          out_free, accept, full, too_long_now, at_limit;
   logic                          load, is_last;
   rftq_pkg::cmd_type             cmd;
   logic [IDX_W-1:0]              meta_len;
   logic [rftq_pkg::REPEAT_W-1:0] meta_rep, rep_dec;
   logic [rftq_pkg::BYTE_W-1:0]   data_byte;
   logic [rftq_pkg::REPEAT_W-1:0] repeat_count;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign data_byte    = req_tdata[rftq_pkg::BYTE_W-1:0];
   assign repeat_count = req_tdata[rftq_pkg::BYTE_W +: rftq_pkg::REPEAT_W];
   assign cmd          = rftq_pkg::cmd_type'(req_tuser);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == rftq_pkg::S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = total_ff >= CNT_W'(QUEUE_DEPTH);
   assign at_limit   = bidx_ff >= IDX_W'(MAX_FRAME_LEN);
   assign too_long_now = too_long_ff || at_limit;
   assign meta_len   = meta_q[META_W-1 -: IDX_W];
   assign meta_rep   = meta_q[rftq_pkg::REPEAT_W-1:0];
   assign rep_dec    = meta_rep - 1'b1;
   assign is_last    = send_idx_ff == send_len_ff - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rftq_pkg::S_IDLE: begin
            if (accept && cmd == rftq_pkg::CMD_SEND && total_ff != '0) begin
               state_in = rftq_pkg::S_META;
            end
         end
         rftq_pkg::S_META: begin
            state_in = (meta_rep == '0) ? rftq_pkg::S_IDLE : rftq_pkg::S_BYTES;
         end
         rftq_pkg::S_BYTES: begin
            if (out_free && is_last) begin
               state_in = rftq_pkg::S_IDLE;
            end
         end
         default: state_in = rftq_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      total_in      = total_ff;
      bidx_in       = bidx_ff;
      too_long_in   = too_long_ff;
      slot_in       = slot_ff;
      send_idx_in   = send_idx_ff;
      send_len_in   = send_len_ff;
      load          = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      frame_we      = 1'b0;
      frame_waddr   = ADDR_W'(tail_ff) * ADDR_W'(MAX_FRAME_LEN) + ADDR_W'(bidx_ff);
      frame_re      = 1'b0;
      frame_raddr   = ADDR_W'(slot_ff) * ADDR_W'(MAX_FRAME_LEN);
      meta_we       = 1'b0;
      meta_re       = 1'b0;
      meta_waddr    = tail_ff;
      meta_wdata    = {bidx_ff + 1'b1, repeat_count};

      unique case (state_ff)
         rftq_pkg::S_IDLE: begin
            if (accept) begin
               case (cmd)
                  rftq_pkg::CMD_PUSH: begin
                     if (at_limit) begin
                        too_long_in = 1'b1;
                     end else begin
                        frame_we = !full;
                        bidx_in  = bidx_ff + 1'b1;
                     end
                     if (req_tlast) begin
                        load          = 1'b1;
                        rsp_kind_in   = rftq_pkg::KIND_STATUS;
                        rsp_byte_in   = '0;
                        rsp_last_in   = 1'b0;
                        if (full) begin
                           rsp_status_in = rftq_pkg::STATUS_FULL;
                        end else if (too_long_now) begin
                           rsp_status_in = rftq_pkg::STATUS_TOO_LONG;
                        end else begin
                           rsp_status_in = rftq_pkg::STATUS_ACCEPTED;
                           meta_we       = 1'b1;
                           tail_in       = ring_next(tail_ff);
                           total_in      = total_ff + 1'b1;
                        end
                        bidx_in     = '0;
                        too_long_in = 1'b0;
                     end
                  end
                  rftq_pkg::CMD_SEND: begin
                     meta_re = total_ff != '0;
                     slot_in = head_ff;
                  end
                  rftq_pkg::CMD_CLEAR: begin
                     head_in     = '0;
                     tail_in     = '0;
                     total_in    = '0;
                     bidx_in     = '0;
                     too_long_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         rftq_pkg::S_META: begin
            if (meta_rep != '0) begin
               meta_we     = 1'b1;
               meta_waddr  = slot_ff;
               meta_wdata  = {meta_len, rep_dec};
               if (rep_dec == '0) begin
                  head_in  = ring_next(head_ff);
                  total_in = total_ff - 1'b1;
               end
               send_len_in = meta_len;
               send_idx_in = '0;
               frame_re    = 1'b1;
            end
         end
         rftq_pkg::S_BYTES: begin
            frame_raddr = ADDR_W'(slot_ff) * ADDR_W'(MAX_FRAME_LEN)
                        + ADDR_W'(send_idx_ff) + 1'b1;
            if (out_free) begin
               load          = 1'b1;
               rsp_kind_in   = rftq_pkg::KIND_BYTE;
               rsp_status_in = rftq_pkg::STATUS_ACCEPTED;
               rsp_byte_in   = frame_q;
               rsp_last_in   = is_last;
               if (!is_last) begin
                  send_idx_in = send_idx_ff + 1'b1;
                  frame_re    = 1'b1;
               end
            end
         end
         default: ;
      endcase

      rsp_fill_in  = rftq_pkg::FILL_W'(total_in);
      rsp_empty_in = total_in == '0;
      if (!load) begin
         rsp_fill_in  = rsp_fill_ff;
         rsp_empty_in = rsp_empty_ff;
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rftq_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= '0;
         bidx_ff      <= '0;
         too_long_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         bidx_ff      <= bidx_in;
         too_long_ff  <= too_long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      send_idx_ff   <= send_idx_in;
      send_len_ff   <= send_len_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   // frame memory
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= data_byte;
      end
      if (frame_re) begin
         frame_q <= frame_mem[frame_raddr];
      end
   end

   // entry memory: length and repeat count
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (meta_re) begin
         meta_q <= meta_mem[head_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {1'b0, rsp_fill_ff, rsp_empty_ff, rsp_byte_ff, rsp_status_ff};

endmodule

@@ design/rftq_checker.sv @@
// port level assertions of the repeat frame transmit queue and their bind
module rftq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [rftq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             req_tlast,
   input logic [rftq_pkg::CMD_W-1:0]       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rftq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // status words carry no frame byte and no last mark
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rftq_pkg::KIND_STATUS |->
         !rsp_tlast && rsp_tdata[9:2] == '0
         && (rsp_tdata[1:0] == rftq_pkg::STATUS_ACCEPTED
             || rsp_tdata[1:0] == rftq_pkg::STATUS_FULL
             || rsp_tdata[1:0] == rftq_pkg::STATUS_TOO_LONG))
      else $error("bad status word");

   // byte words carry a zero status
   a_byte_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rftq_pkg::KIND_BYTE |-> rsp_tdata[1:0] == '0)
      else $error("byte word with nonzero status");

   // empty queue reports zero fill
   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[14:11] == '0 && !rsp_tdata[15])
      else $error("empty flag with nonzero fill");

   // a send never overlaps a new request word
   a_no_accept_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rftq_pkg::KIND_BYTE && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a frame");

endmodule

bind repeat_frame_tx_queue_top rftq_checker u_rftq_checker (.*);

@@ test/repeat_frame_tx_queue_top_test.sv @@
// testbench of the repeat frame transmit queue: stream stimulus with idling, self-checking
`timescale 1ns / 1ps

module repeat_frame_tx_queue_top_test;

   localparam int QDEPTH = rftq_pkg::QUEUE_DEPTH_DEF;
   localparam int MAXLEN = rftq_pkg::MAX_FRAME_LEN_DEF;
   localparam logic [rftq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEM_GOAL = 350;

   typedef logic [rftq_pkg::BYTE_W-1:0]   byte_val_type;
   typedef logic [rftq_pkg::REPEAT_W-1:0] repeat_val_type;

   typedef struct {
      logic [rftq_pkg::CMD_W-1:0] cmd;
      byte_val_type               data_byte;
      logic                       last_byte;
      repeat_val_type             repeat_count;
   } req_word_type;

   typedef struct {
      rftq_pkg::kind_type          kind;
      rftq_pkg::status_type        status;
      byte_val_type                frame_byte;
      logic                        frame_last;
      logic                        queue_empty;
      logic [rftq_pkg::FILL_W-1:0] queue_fill;
   } rsp_word_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rftq_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tlast = 1'b0;
   logic [rftq_pkg::CMD_W-1:0]       req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rftq_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             rsp_tuser;

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   int           error_count = 0;
   int           item_count = 0;
   logic         req_taken = 1'b0;

   // predictor state
   byte_val_type   slot_bytes[QDEPTH][MAXLEN];
   int             slot_len[QDEPTH];
   repeat_val_type slot_repeat[QDEPTH];
   int             head_slot = 0;
   int             tail_slot = 0;
   int             held = 0;
   int             fill_index = 0;
   bit             overlong = 0;

   repeat_frame_tx_queue_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      error_count++;
   endtask

   function automatic void expect_word(rftq_pkg::kind_type kind,
                                       rftq_pkg::status_type status,
                                       byte_val_type fbyte, logic flast);
      rsp_word_type w;
      w.kind        = kind;
      w.status      = status;
      w.frame_byte  = fbyte;
      w.frame_last  = flast;
      w.queue_empty = (held == 0);
      w.queue_fill  = held[rftq_pkg::FILL_W-1:0];
      expected_words.push_back(w);
   endfunction

   function automatic void predict_queue(req_word_type r);
      bit                   full;
      rftq_pkg::status_type st;
      int                   slot;
      int                   n;
      full = held >= QDEPTH;
      if (r.cmd == rftq_pkg::CMD_PUSH) begin
         if (fill_index >= MAXLEN) begin
            overlong = 1;
         end else begin
            if (!full) slot_bytes[tail_slot][fill_index] = r.data_byte;
            fill_index++;
         end
         if (r.last_byte) begin
            if (full) begin
               st = rftq_pkg::STATUS_FULL;
            end else if (overlong) begin
               st = rftq_pkg::STATUS_TOO_LONG;
            end else begin
               slot_len[tail_slot]    = fill_index;
               slot_repeat[tail_slot] = r.repeat_count;
               tail_slot = (tail_slot + 1) % QDEPTH;
               held++;
               st = rftq_pkg::STATUS_ACCEPTED;
            end
            fill_index = 0;
            overlong   = 0;
            expect_word(rftq_pkg::KIND_STATUS, st, '0, 1'b0);
         end
      end else if (r.cmd == rftq_pkg::CMD_SEND) begin
         slot = head_slot;
         if (held != 0 && slot_repeat[slot] != 0) begin
            n = slot_len[slot];
            slot_repeat[slot]--;
            if (slot_repeat[slot] == 0) begin
               head_slot = (head_slot + 1) % QDEPTH;
               held--;
            end
            for (int i = 0; i < n; i++)
               expect_word(rftq_pkg::KIND_BYTE, rftq_pkg::STATUS_ACCEPTED,
                           slot_bytes[slot][i], i == n - 1);
         end
      end else if (r.cmd == rftq_pkg::CMD_CLEAR) begin
         head_slot  = 0;
         tail_slot  = 0;
         held       = 0;
         fill_index = 0;
         overlong   = 0;
      end
   endfunction

   task automatic add_word(logic [rftq_pkg::CMD_W-1:0] cmd, byte_val_type db, logic lb,
                           repeat_val_type rc);
      req_word_type w;
      w.cmd          = cmd;
      w.data_byte    = db;
      w.last_byte    = lb;
      w.repeat_count = rc;
      pending_words.push_back(w);
      if (cmd != CMD_UNUSED) item_count++;
   endtask

   task automatic add_frame(int len, repeat_val_type rc);
      for (int i = 0; i < len; i++)
         add_word(rftq_pkg::CMD_PUSH, byte_val_type'($urandom), i == len - 1,
                  (i == len - 1) ? rc : repeat_val_type'($urandom));
   endtask

   task automatic add_send();
      add_word(rftq_pkg::CMD_SEND, byte_val_type'($urandom), ($urandom_range(0, 1) != 0),
               repeat_val_type'($urandom));
   endtask

   // driver
   int burst_left = 8;
   int gap_left = 0;

   always @(negedge clock) begin
      req_word_type w;
      logic         nv;
      if (!reset && !(req_tvalid && !req_taken)) begin
         nv = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_tdata <= {w.repeat_count, w.data_byte};
            req_tlast <= w.last_byte;
            req_tuser <= w.cmd;
            nv = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         req_tvalid <= nv;
      end
   end

   // receiver stall pattern
   int rx_cycle = 0;
   int rx_mode = 0;
   int hold_left = 0;
   logic hold_val = 1'b1;

   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 2);
      if (rx_mode == 0) begin
         rsp_tready <= 1'b1;
      end else if (rx_mode == 1) begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
      end else begin
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            hold_val  = ($urandom_range(0, 1) != 0);
            hold_left = $urandom_range(0, 12);
         end
         rsp_tready <= hold_val;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      req_word_type r;
      rsp_word_type e;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         r.cmd          = req_tuser;
         r.data_byte    = req_tdata[rftq_pkg::BYTE_W-1:0];
         r.last_byte    = req_tlast;
         r.repeat_count = req_tdata[rftq_pkg::BYTE_W +: rftq_pkg::REPEAT_W];
         predict_queue(r);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, tdata", int'(rsp_tdata), 0);
         end else begin
            e = expected_words.pop_front();
            if (rsp_tuser !== e.kind)
               report_mismatch("result_kind", int'(rsp_tuser), int'(e.kind));
            if (rsp_tdata[1:0] !== e.status)
               report_mismatch("push_status", int'(rsp_tdata[1:0]), int'(e.status));
            if (rsp_tdata[9:2] !== e.frame_byte)
               report_mismatch("frame_byte", int'(rsp_tdata[9:2]), int'(e.frame_byte));
            if (rsp_tlast !== e.frame_last)
               report_mismatch("frame_last", int'(rsp_tlast), int'(e.frame_last));
            if (rsp_tdata[10] !== e.queue_empty)
               report_mismatch("queue_empty", int'(rsp_tdata[10]), int'(e.queue_empty));
            if (rsp_tdata[14:11] !== e.queue_fill)
               report_mismatch("queue_fill", int'(rsp_tdata[14:11]), int'(e.queue_fill));
            if (rsp_tdata[15] !== 1'b0) report_mismatch("pad", int'(rsp_tdata[15]), 0);
         end
      end
   end

   // watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout waiting for a handshake");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int             r;
      int             len;
      repeat_val_type rc;

      // directed: empty send, unused command, stuck zero-count head
      add_send();
      add_word(CMD_UNUSED, 8'hff, 1'b1, 8'hff);
      add_word(rftq_pkg::CMD_PUSH, 8'h00, 1'b1, 8'h00);
      add_send();
      add_word(rftq_pkg::CMD_CLEAR, 8'h00, 1'b0, 8'h00);
      // two-byte frame with extreme bytes, sent twice then retired
      add_word(rftq_pkg::CMD_PUSH, 8'hff, 1'b0, 8'hff);
      add_word(rftq_pkg::CMD_PUSH, 8'h00, 1'b1, 8'h02);
      add_send();
      add_send();
      add_send();
      // clear abandons a partly pushed frame
      add_word(rftq_pkg::CMD_PUSH, 8'ha5, 1'b0, 8'h00);
      add_word(rftq_pkg::CMD_CLEAR, 8'hff, 1'b1, 8'hff);
      add_word(rftq_pkg::CMD_PUSH, 8'h5a, 1'b1, 8'h01);
      add_send();
      // fill the queue, then one more frame is rejected as full
      for (int i = 0; i < QDEPTH + 1; i++) add_frame(1, 8'hff);
      add_send();
      add_word(rftq_pkg::CMD_CLEAR, 8'h00, 1'b0, 8'h00);

      while (item_count < ITEM_GOAL) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            case ($urandom_range(0, 19))
               0: len = MAXLEN;
               1: len = $urandom_range(MAXLEN + 1, MAXLEN + 6);
               default: len = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
               0: rc = 8'h00;
               1: rc = repeat_val_type'($urandom);
               default: rc = repeat_val_type'($urandom_range(1, 3));
            endcase
            add_frame(len, rc);
         end else if (r < 85) begin
            repeat ($urandom_range(1, 3)) add_send();
         end else if (r < 90) begin
            add_word(rftq_pkg::CMD_CLEAR, byte_val_type'($urandom),
                     ($urandom_range(0, 1) != 0), repeat_val_type'($urandom));
         end else if (r < 95) begin
            add_word(CMD_UNUSED, byte_val_type'($urandom),
                     ($urandom_range(0, 1) != 0), repeat_val_type'($urandom));
         end else begin
            repeat ($urandom_range(1, 4))
               add_word(rftq_pkg::CMD_PUSH, byte_val_type'($urandom), 1'b0,
                        repeat_val_type'($urandom));
            add_word(rftq_pkg::CMD_CLEAR, byte_val_type'($urandom),
                     ($urandom_range(0, 1) != 0), repeat_val_type'($urandom));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_words.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
